FILE: hw/rtl/wcip_pkg.sv
// Package for the wide character integer parser.
// Holds character codes, radix codes, the parse phase type, the control
// struct shared between the top level and the step logic, and helper functions.
package wcip_pkg;

  // Default sizes for the top-level parameters
  localparam int VALUE_BITS_DEF    = 32;
  localparam int POSITION_BITS_DEF = 16;

  // Fixed field widths
  localparam int BASE_W  = 6;
  localparam int CHAR_W  = 32;
  localparam int END_W   = 16;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_TAB   = 32'h0000_0009;
  localparam logic [CHAR_W-1:0] CH_CR    = 32'h0000_000D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 32'h0000_0020;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 32'h0000_002B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 32'h0000_002D;
  localparam logic [CHAR_W-1:0] CH_0     = 32'h0000_0030;
  localparam logic [CHAR_W-1:0] CH_9     = 32'h0000_0039;
  localparam logic [CHAR_W-1:0] CH_UA    = 32'h0000_0041;
  localparam logic [CHAR_W-1:0] CH_UX    = 32'h0000_0058;
  localparam logic [CHAR_W-1:0] CH_UZ    = 32'h0000_005A;
  localparam logic [CHAR_W-1:0] CH_LA    = 32'h0000_0061;
  localparam logic [CHAR_W-1:0] CH_LX    = 32'h0000_0078;
  localparam logic [CHAR_W-1:0] CH_LZ    = 32'h0000_007A;

  // Radix codes
  localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

  // Letter digits start at ten
  localparam logic [CHAR_W-1:0] LETTER_OFS = 32'd10;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD,
    PH_SIGNED,
    PH_ZERO,
    PH_HEXFIRST,
    PH_DIGITS
  } phase_e;

  typedef struct packed {
    phase_e              phase;
    logic [BASE_W-1:0]   base;
    logic                neg;
    logic                any_digit;
    logic                ovf;
  } ctrl_t;

  typedef struct packed {
    logic              ok;
    logic [BASE_W-1:0] val;
  } digit_t;

  // Digit value 0..35 of a character, ok low when it is no digit or letter
  function automatic digit_t digit_of(input logic [CHAR_W-1:0] c);
    digit_t            r;
    logic [CHAR_W-1:0] off;
    r.ok = 1'b1;
    off  = '0;
    if (c inside {[CH_0:CH_9]}) begin
      off = c - CH_0;
    end else if (c inside {[CH_UA:CH_UZ]}) begin
      off = c - CH_UA + LETTER_OFS;
    end else if (c inside {[CH_LA:CH_LZ]}) begin
      off = c - CH_LA + LETTER_OFS;
    end else begin
      r.ok = 1'b0;
    end
    r.val = off[BASE_W-1:0];
    return r;
  endfunction

  // C-locale white space: blank, tab through carriage return
  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
  endfunction

endpackage

FILE: hw/rtl/wcip_step.sv
// Per-character step logic of the integer parser: next parse state and result.
// Purely combinational; depends on wcip_pkg.
module wcip_step #(
  parameter int VALUE_BITS    = wcip_pkg::VALUE_BITS_DEF,
  parameter int POSITION_BITS = wcip_pkg::POSITION_BITS_DEF
) (
  input  logic                           start_i,
  input  logic [wcip_pkg::BASE_W-1:0]    base_i,
  input  logic [wcip_pkg::CHAR_W-1:0]    char_i,
  input  wcip_pkg::ctrl_t                ctrl_i,
  input  logic [VALUE_BITS-1:0]          acc_i,
  input  logic [POSITION_BITS-1:0]       pos_i,
  output wcip_pkg::ctrl_t                ctrl_o,
  output logic [VALUE_BITS-1:0]          acc_o,
  output logic [POSITION_BITS-1:0]       pos_o,
  output logic                           emit_o,
  output logic signed [VALUE_BITS-1:0]   value_o,
  output logic                           overflow_o,
  output logic                           digits_found_o,
  output logic [wcip_pkg::END_W-1:0]     end_index_o
);

  localparam int ProdW = VALUE_BITS + wcip_pkg::BASE_W;
  localparam int MacW  = ProdW + 1;

  wcip_pkg::ctrl_t              c;
  wcip_pkg::digit_t             dg;
  logic [VALUE_BITS-1:0]        acc;
  logic [VALUE_BITS-1:0]        vmax;
  logic [VALUE_BITS-1:0]        vmin;
  logic [wcip_pkg::BASE_W-1:0]  radix;
  logic [ProdW-1:0]             prod;
  logic [MacW-1:0]              mac;
  logic [MacW-1:0]              limit;
  logic                         run;
  logic                         do_first;
  logic                         do_digit;

  assign vmax = {1'b0, {(VALUE_BITS-1){1'b1}}};
  assign vmin = {1'b1, {(VALUE_BITS-1){1'b0}}};
  assign dg   = wcip_pkg::digit_of(char_i);

  always_comb begin
    c        = ctrl_i;
    acc      = acc_i;
    pos_o    = pos_i;
    run      = 1'b1;
    do_first = 1'b0;
    do_digit = 1'b0;
    emit_o   = 1'b0;
    radix    = '0;
    prod     = '0;
    mac      = '0;
    limit    = '0;

    // Start mark restarts the parse at index 0; otherwise, unless idle, advance the position, saturating at its maximum
    if (start_i) begin
      c.phase     = wcip_pkg::PH_LEAD;
      c.base      = base_i;
      c.neg       = 1'b0;
      c.any_digit = 1'b0;
      c.ovf       = 1'b0;
      acc         = '0;
      pos_o       = '0;
    end else if (c.phase == wcip_pkg::PH_IDLE) begin
      run = 1'b0;
    end else if (pos_i != {POSITION_BITS{1'b1}}) begin
      pos_o = pos_i + POSITION_BITS'(1);
    end

    // Phase dispatch
    if (run) begin
      case (c.phase)
        wcip_pkg::PH_LEAD: begin
          if (wcip_pkg::is_space(char_i)) begin
            c.phase = wcip_pkg::PH_LEAD;
          end else if (char_i == wcip_pkg::CH_MINUS) begin
            c.neg   = 1'b1;
            c.phase = wcip_pkg::PH_SIGNED;
          end else if (char_i == wcip_pkg::CH_PLUS) begin
            c.phase = wcip_pkg::PH_SIGNED;
          end else begin
            do_first = 1'b1;
          end
        end
        wcip_pkg::PH_SIGNED: begin
          do_first = 1'b1;
        end
        wcip_pkg::PH_ZERO: begin
          if (char_i == wcip_pkg::CH_LX || char_i == wcip_pkg::CH_UX) begin
            c.base  = wcip_pkg::BASE_HEX;
            c.phase = wcip_pkg::PH_HEXFIRST;
          end else begin
            // the leading zero counts as a digit; accumulator is still zero
            if (c.base == wcip_pkg::BASE_AUTO) c.base = wcip_pkg::BASE_OCT;
            c.any_digit = 1'b1;
            do_digit    = 1'b1;
          end
        end
        wcip_pkg::PH_HEXFIRST, wcip_pkg::PH_DIGITS: begin
          do_digit = 1'b1;
        end
        default: begin
          c.phase = wcip_pkg::PH_IDLE;
        end
      endcase
    end

    // First character after white space and sign: zero may open a prefix
    if (do_first) begin
      if ((c.base == wcip_pkg::BASE_AUTO || c.base == wcip_pkg::BASE_HEX) &&
          char_i == wcip_pkg::CH_0) begin
        c.phase = wcip_pkg::PH_ZERO;
      end else begin
        if (c.base == wcip_pkg::BASE_AUTO) c.base = wcip_pkg::BASE_DEC;
        do_digit = 1'b1;
      end
    end

    // Digit: multiply-add with range check, or end of number
    if (do_digit) begin
      radix = (c.base == wcip_pkg::BASE_AUTO) ? wcip_pkg::BASE_DEC : c.base;
      if (!dg.ok || dg.val >= c.base) begin
        emit_o  = 1'b1;
        c.phase = wcip_pkg::PH_IDLE;
      end else begin
        prod  = ProdW'(acc) * ProdW'(radix);
        mac   = MacW'(prod) + MacW'(dg.val);
        limit = MacW'(c.neg ? vmin : vmax);
        if (!c.ovf && (mac > limit)) begin
          c.ovf = 1'b1;
        end else if (!c.ovf) begin
          acc = mac[VALUE_BITS-1:0];
        end
        c.any_digit = 1'b1;
        c.phase     = wcip_pkg::PH_DIGITS;
      end
    end
  end

  assign ctrl_o = c;
  assign acc_o  = acc;

  // Result fields, saturated on overflow
  assign value_o        = c.ovf ? (c.neg ? vmin : vmax) : (c.neg ? (~acc + VALUE_BITS'(1)) : acc);
  assign overflow_o     = c.ovf;
  assign digits_found_o = c.any_digit;
  assign end_index_o    = c.any_digit ? wcip_pkg::END_W'(pos_o) : '0;

endmodule

FILE: hw/rtl/wcip_out_reg.sv
// Result register of the integer parser with valid/stall handshake.
// Depends on wcip_pkg for field widths.
module wcip_out_reg #(
  parameter int VALUE_BITS = wcip_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic signed [VALUE_BITS-1:0]  value_i,
  input  logic                          overflow_i,
  input  logic                          digits_found_i,
  input  logic [wcip_pkg::END_W-1:0]    end_index_i,
  input  logic                          stall_i,
  output logic                          free_o,
  output logic                          valid_o,
  output logic signed [VALUE_BITS-1:0]  value_o,
  output logic                          overflow_o,
  output logic                          digits_found_o,
  output logic [wcip_pkg::END_W-1:0]    end_index_o
);

  logic                         valid_q;
  logic signed [VALUE_BITS-1:0] value_q;
  logic                         overflow_q;
  logic                         digits_found_q;
  logic [wcip_pkg::END_W-1:0]   end_index_q;

  // Slot can take a new result when empty or being drained this cycle
  assign free_o = !valid_q || !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      value_q        <= value_i;
      overflow_q     <= overflow_i;
      digits_found_q <= digits_found_i;
      end_index_q    <= end_index_i;
    end
  end

  assign valid_o        = valid_q;
  assign value_o        = value_q;
  assign overflow_o     = overflow_q;
  assign digits_found_o = digits_found_q;
  assign end_index_o    = end_index_q;

endmodule

FILE: hw/rtl/wide_char_integer_parser.sv
// Wide character integer parser: top level with input register, parse state
// and result register. Depends on wcip_pkg, wcip_step and wcip_out_reg.
//
// Parses one wide character per transaction, strtol style, and returns one
// result transaction on the character that ends the number. Throughput is one
// character per cycle while the input is not stalled. The terminating character
// passes through the input register and the step logic into the result
// register, which raises out_valid_o once loaded. The per-cycle limit is the
// accumulator update, a multiply by the radix, digit add and signed-limit compare.
// The input stalls only while the result register is full and stalled.
module wide_char_integer_parser #(
  parameter int VALUE_BITS    = wcip_pkg::VALUE_BITS_DEF,
  parameter int POSITION_BITS = wcip_pkg::POSITION_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          start_req_i,
  input  logic [wcip_pkg::BASE_W-1:0]   base_i,
  input  logic [wcip_pkg::CHAR_W-1:0]   char_code_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [VALUE_BITS-1:0]  value_o,
  output logic                          overflow_o,
  output logic                          digits_found_o,
  output logic [wcip_pkg::END_W-1:0]    end_index_o
);

  // Input register
  logic                         s1_valid_q;
  logic                         s1_start_q;
  logic [wcip_pkg::BASE_W-1:0]  s1_base_q;
  logic [wcip_pkg::CHAR_W-1:0]  s1_char_q;

  // Parse state
  wcip_pkg::ctrl_t              ctrl_q, ctrl_d;
  logic [VALUE_BITS-1:0]        acc_q, acc_d;
  logic [POSITION_BITS-1:0]     pos_q, pos_d;

  logic                         out_free;
  logic                         advance;
  logic                         emit;
  logic signed [VALUE_BITS-1:0] res_value;
  logic                         res_overflow;
  logic                         res_digits;
  logic [wcip_pkg::END_W-1:0]   res_end_index;

  assign advance    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;

  // Input register stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_start_q <= start_req_i;
      s1_base_q  <= base_i;
      s1_char_q  <= char_code_i;
    end
  end

  wcip_step #(
    .VALUE_BITS    (VALUE_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_step (
    .start_i        (s1_start_q),
    .base_i         (s1_base_q),
    .char_i         (s1_char_q),
    .ctrl_i         (ctrl_q),
    .acc_i          (acc_q),
    .pos_i          (pos_q),
    .ctrl_o         (ctrl_d),
    .acc_o          (acc_d),
    .pos_o          (pos_d),
    .emit_o         (emit),
    .value_o        (res_value),
    .overflow_o     (res_overflow),
    .digits_found_o (res_digits),
    .end_index_o    (res_end_index)
  );

  // Parse state update, one character per advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '{phase: wcip_pkg::PH_IDLE, base: '0, neg: 1'b0, any_digit: 1'b0, ovf: 1'b0};
      acc_q  <= '0;
      pos_q  <= '0;
    end else if (advance) begin
      ctrl_q <= ctrl_d;
      acc_q  <= acc_d;
      pos_q  <= pos_d;
    end
  end

  wcip_out_reg #(
    .VALUE_BITS (VALUE_BITS)
  ) u_out_reg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (advance && emit),
    .value_i        (res_value),
    .overflow_i     (res_overflow),
    .digits_found_i (res_digits),
    .end_index_i    (res_end_index),
    .stall_i        (out_stall_i),
    .free_o         (out_free),
    .valid_o        (out_valid_o),
    .value_o        (value_o),
    .overflow_o     (overflow_o),
    .digits_found_o (digits_found_o),
    .end_index_o    (end_index_o)
  );

endmodule

FILE: hw/rtl/wcip_checker.sv
// Port-level checker for the wide character integer parser, bound to the top.
// Depends on wcip_pkg for field widths.
module wcip_checker #(
  parameter int VALUE_BITS = wcip_pkg::VALUE_BITS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [VALUE_BITS-1:0]  value_o,
  input logic                          overflow_o,
  input logic                          digits_found_o,
  input logic [wcip_pkg::END_W-1:0]    end_index_o
);

  logic signed [VALUE_BITS-1:0] vmax;
  logic signed [VALUE_BITS-1:0] vmin;

  assign vmax = {1'b0, {(VALUE_BITS-1){1'b1}}};
  assign vmin = {1'b1, {(VALUE_BITS-1){1'b0}}};

  // Stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_o) && $stable(end_index_o))
    else $error("result changed while stalled");

  // Input is held off only while a result waits under stall
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with no blocked result");

  // Overflow can only come from consumed digits
  a_ovf_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> digits_found_o)
    else $error("overflow without digits");

  // No digits gives an all-zero result
  a_no_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !digits_found_o |-> value_o == '0 && end_index_o == '0 && !overflow_o)
    else $error("empty parse with nonzero result");

  // Overflow saturates to an end of the signed range
  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> value_o == vmax || value_o == vmin)
    else $error("overflow value not saturated");

endmodule

bind wide_char_integer_parser wcip_checker #(
  .VALUE_BITS (VALUE_BITS)
) u_wcip_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .value_o        (value_o),
  .overflow_o     (overflow_o),
  .digits_found_o (digits_found_o),
  .end_index_o    (end_index_o)
);
